/* src/gaussian_blur_rgb_clipped_core_assert.svh */
// Assertion macros shared by the blur core.
`ifndef GAUSSIAN_BLUR_RGB_CLIPPED_CORE_ASSERT_SVH
`define GAUSSIAN_BLUR_RGB_CLIPPED_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define GBR_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define GBR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GBR_ASSERT_ALWAYS(lbl, cond)
`define GBR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* src/gbr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package gbr_pkg;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_RADIUS  = 3;
  localparam int WEIGHT_BITS = 16;
  localparam int MAX_HEIGHT  = 4096;
  localparam int COL_W       = 10;
  localparam int ROW_W       = 12;
  localparam int DIST_W      = 4;
  localparam int PIX_W       = 24;

  typedef enum logic [2:0] {
    REG_RADIUS   = 3'd0,
    REG_W_CENTER = 3'd1,
    REG_W_DIST1  = 3'd2,
    REG_W_DIST2  = 3'd3,
    REG_W_DIST3  = 3'd4,
    REG_WIDTH    = 3'd5,
    REG_HEIGHT   = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_WAIT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic clear;
    logic issue;
    logic in_win;
  } tap_ctrl_t;
endpackage
`default_nettype wire

/* src/gbr_line_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
module gbr_line_mem #(
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = 13
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [ADDR_W-1:0]        waddr,
  input  wire logic [gbr_pkg::PIX_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0]        raddr,
  output logic      [gbr_pkg::PIX_W-1:0] rdata
);
  logic [gbr_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/gbr_tap_mac.sv */
`timescale 1ns / 1ps
`default_nettype none
module gbr_tap_mac #(
  parameter int WB    = 16,
  parameter int ACC_W = 46
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire gbr_pkg::tap_ctrl_t        ctrl,
  input  wire logic [WB-1:0]             wa,
  input  wire logic [WB-1:0]             wb,
  input  wire logic [gbr_pkg::PIX_W-1:0] rd_data,
  output logic      [ACC_W-1:0]          acc_b,
  output logic      [ACC_W-1:0]          acc_g,
  output logic      [ACC_W-1:0]          acc_r,
  output logic                           busy
);
  localparam int WT_W = 2 * WB;
  localparam int PR_W = WT_W + 8;

  logic            v1_r, v2_r;
  logic [WT_W-1:0] wt_r;
  logic [PR_W-1:0] pb_r, pg_r, pr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctrl.issue && ctrl.in_win;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    wt_r <= WT_W'(wa) * WT_W'(wb);
    pb_r <= PR_W'(rd_data[7:0]) * PR_W'(wt_r);
    pg_r <= PR_W'(rd_data[15:8]) * PR_W'(wt_r);
    pr_r <= PR_W'(rd_data[23:16]) * PR_W'(wt_r);
    if (ctrl.clear) begin
      acc_b <= '0;
      acc_g <= '0;
      acc_r <= '0;
    end else if (v2_r) begin
      acc_b <= acc_b + ACC_W'(pb_r);
      acc_g <= acc_g + ACC_W'(pg_r);
      acc_r <= acc_r + ACC_W'(pr_r);
    end
  end

  assign busy = v1_r || v2_r;
endmodule
`default_nettype wire

/* src/gaussian_blur_rgb_clipped_core.sv */
// Streaming Gaussian blur of RGB pixels in raster order, kernel radius 0 to 3.
// Input channel: in_valid/in_ready with a request type (pixel or drain) and
// the three colour channels. Output channel: out_valid/out_ready with the
// blurred colour, its row and column, and a flag on the last pixel of a frame.
// Configuration: write cfg_data to register cfg_index while cfg_we is high;
// the user must change registers only while the block is idle, as the block itself lacks any guard for this.
// One request is handled at a time; a new request is taken only once the last
// one is through. The single read port of the line buffer delivers one window
// tap per cycle to a shared multiply-accumulate unit while a pixel is computed.
// A finished pixel sits in the output register; the next request is taken
// while it waits, and a further result waits in the core until the receiver
// takes the first one.
// Reset clears positions, control state and the output valid flag and loads
// the default kernel and frame size. The line buffer needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "gaussian_blur_rgb_clipped_core_assert.svh"
module gaussian_blur_rgb_clipped_core #(
  parameter int MAX_WIDTH   = gbr_pkg::MAX_WIDTH,
  parameter int MAX_RADIUS  = gbr_pkg::MAX_RADIUS,
  parameter int WEIGHT_BITS = gbr_pkg::WEIGHT_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_blue_in,
  input  wire logic [7:0]  in_green_in,
  input  wire logic [7:0]  in_red_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_blue_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_red_out,
  output logic [11:0]      out_row,
  output logic [9:0]       out_col,
  output logic             out_frame_done,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int WB        = WEIGHT_BITS;
  localparam int ROWS_KEPT = 2 * MAX_RADIUS + 2;
  localparam int SLOT_W    = $clog2(ROWS_KEPT);
  localparam int DEPTH     = ROWS_KEPT * MAX_WIDTH;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int ACC_W     = 2 * WB + 8 + 6;
  localparam int ST_W      = SLOT_W + gbr_pkg::DIST_W;
  localparam int COL_W     = gbr_pkg::COL_W;
  localparam int ROW_W     = gbr_pkg::ROW_W;
  localparam int DW        = gbr_pkg::DIST_W;
  localparam logic [ADDR_W-1:0] MW      = ADDR_W'(MAX_WIDTH);
  localparam logic [10:0]       MAXW_11 = 11'(MAX_WIDTH);
  localparam logic [12:0]       MAXH_13 = 13'(gbr_pkg::MAX_HEIGHT);
  localparam logic [1:0]        MAXR_2  = 2'(MAX_RADIUS);

  gbr_pkg::state_t state_r, state_nxt;

  logic [1:0]  radius_r;
  logic [WB-1:0] w0_r, w1_r, w2_r, w3_r;
  logic [10:0] width_r;
  logic [12:0] height_r;

  logic [ROW_W-1:0]  in_row_r, emit_row_r;
  logic [COL_W-1:0]  in_col_r, emit_col_r;
  logic [SLOT_W-1:0] in_slot_r, emit_slot_r;
  logic              input_done_r;
  logic signed [DW-1:0] dy_r, dx_r;

  logic [10:0] w_eff;
  logic [12:0] h_eff;
  logic [1:0]  r_eff;
  logic signed [DW-1:0] r_s;
  logic [WB+15:0] cfg_ext;

  logic accept, pix_write, ready, last_tap, load_out;
  logic [12:0] nr;
  logic [10:0] nc;
  logic signed [ROW_W+1:0] tr;
  logic signed [COL_W+1:0] tc;
  logic signed [ST_W-1:0]  st;
  logic [SLOT_W-1:0] tap_slot;
  logic tap_in_win;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [gbr_pkg::PIX_W-1:0] rdata;
  gbr_pkg::tap_ctrl_t ctrl;
  logic [WB-1:0] wa, wb;
  logic [ACC_W-1:0] acc_b, acc_g, acc_r;
  logic mac_busy;
  logic emit_col_wrap, emit_row_wrap;

  function automatic logic [WB-1:0] dist_w(input logic signed [DW-1:0] d,
                                           input logic [WB-1:0] a0,
                                           input logic [WB-1:0] a1,
                                           input logic [WB-1:0] a2,
                                           input logic [WB-1:0] a3);
    logic [DW-1:0] m;
    logic [WB-1:0] v;
    m = d[DW-1] ? DW'(-d) : DW'(d);
    case (m)
      DW'(0):  v = a0;
      DW'(1):  v = a1;
      DW'(2):  v = a2;
      DW'(3):  v = a3;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] sat8(input logic [ACC_W-1:0] a);
    logic [ACC_W-2*WB-1:0] hi;
    hi = a[ACC_W-1:2*WB];
    return (hi > (ACC_W-2*WB)'(255)) ? 8'hFF : hi[7:0];
  endfunction

  assign w_eff = (width_r == 11'd0) ? 11'd1 : ((width_r > MAXW_11) ? MAXW_11 : width_r);
  assign h_eff = (height_r == 13'd0) ? 13'd1 : ((height_r > MAXH_13) ? MAXH_13 : height_r);
  assign r_eff = (radius_r > MAXR_2) ? MAXR_2 : radius_r;
  assign r_s   = DW'(r_eff);
  assign cfg_ext = {{WB{1'b0}}, cfg_data};

  assign accept    = in_valid && in_ready;
  assign pix_write = accept && !in_req_type && !input_done_r;

  assign nr = ((13'(emit_row_r) + 13'(r_eff)) > (h_eff - 13'd1)) ? (h_eff - 13'd1)
            : (13'(emit_row_r) + 13'(r_eff));
  assign nc = ((11'(emit_col_r) + 11'(r_eff)) > (w_eff - 11'd1)) ? (w_eff - 11'd1)
            : (11'(emit_col_r) + 11'(r_eff));
  assign ready = input_done_r || (13'(in_row_r) > nr)
              || ((13'(in_row_r) == nr) && (11'(in_col_r) > nc));

  assign tr = $signed({2'b00, emit_row_r}) + (ROW_W+2)'(dy_r);
  assign tc = $signed({2'b00, emit_col_r}) + (COL_W+2)'(dx_r);
  assign tap_in_win = !tr[ROW_W+1] && (tr[ROW_W:0] < h_eff)
                   && !tc[COL_W+1] && (tc[COL_W:0] < w_eff);
  assign st = $signed({{DW{1'b0}}, emit_slot_r}) + ST_W'(dy_r);
  always_comb begin
    if (st < 0) begin
      tap_slot = SLOT_W'(st + ST_W'(ROWS_KEPT));
    end else if (st >= ST_W'(ROWS_KEPT)) begin
      tap_slot = SLOT_W'(st - ST_W'(ROWS_KEPT));
    end else begin
      tap_slot = SLOT_W'(st);
    end
  end
  assign raddr = ADDR_W'(tap_slot) * MW + ADDR_W'(tc[COL_W-1:0]);
  assign waddr = ADDR_W'(in_slot_r) * MW + ADDR_W'(in_col_r);
  assign last_tap = (dy_r == r_s) && (dx_r == r_s);
  assign wa = dist_w(dy_r, w0_r, w1_r, w2_r, w3_r);
  assign wb = dist_w(dx_r, w0_r, w1_r, w2_r, w3_r);

  assign emit_col_wrap = (11'(emit_col_r) + 11'd1) >= w_eff;
  assign emit_row_wrap = (13'(emit_row_r) + 13'd1) >= h_eff;

  gbr_line_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (pix_write && (11'(in_col_r) < MAXW_11)),
    .waddr (waddr),
    .wdata ({in_red_in, in_green_in, in_blue_in}),
    .raddr (raddr),
    .rdata (rdata)
  );

  gbr_tap_mac #(
    .WB    (WB),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .wa      (wa),
    .wb      (wb),
    .rd_data (rdata),
    .acc_b   (acc_b),
    .acc_g   (acc_g),
    .acc_r   (acc_r),
    .busy    (mac_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    ctrl.clear  = 1'b0;
    ctrl.issue  = 1'b0;
    ctrl.in_win = tap_in_win;
    load_out    = 1'b0;
    unique case (state_r)
      gbr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = gbr_pkg::ST_CHECK;
        end
      end
      gbr_pkg::ST_CHECK: begin
        ctrl.clear = 1'b1;
        state_nxt  = ready ? gbr_pkg::ST_RUN : gbr_pkg::ST_IDLE;
      end
      gbr_pkg::ST_RUN: begin
        ctrl.issue = 1'b1;
        if (last_tap) begin
          state_nxt = gbr_pkg::ST_WAIT;
        end
      end
      gbr_pkg::ST_WAIT: begin
        if (!mac_busy) begin
          state_nxt = gbr_pkg::ST_FIN;
        end
      end
      gbr_pkg::ST_FIN: begin
        if (!out_valid || out_ready) begin
          load_out  = 1'b1;
          state_nxt = gbr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gbr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 2'd3;
      w0_r     <= WB'(17740);
      w1_r     <= WB'(14205);
      w2_r     <= WB'(7293);
      w3_r     <= WB'(2400);
      width_r  <= 11'd1024;
      height_r <= 13'd1024;
    end else if (cfg_we) begin
      unique case (gbr_pkg::reg_idx_t'(cfg_index))
        gbr_pkg::REG_RADIUS:   radius_r <= cfg_data[1:0];
        gbr_pkg::REG_W_CENTER: w0_r     <= cfg_ext[WB-1:0];
        gbr_pkg::REG_W_DIST1:  w1_r     <= cfg_ext[WB-1:0];
        gbr_pkg::REG_W_DIST2:  w2_r     <= cfg_ext[WB-1:0];
        gbr_pkg::REG_W_DIST3:  w3_r     <= cfg_ext[WB-1:0];
        gbr_pkg::REG_WIDTH:    width_r  <= cfg_data[10:0];
        gbr_pkg::REG_HEIGHT:   height_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r     <= '0;
      in_col_r     <= '0;
      in_slot_r    <= '0;
      emit_row_r   <= '0;
      emit_col_r   <= '0;
      emit_slot_r  <= '0;
      input_done_r <= 1'b0;
      dy_r         <= '0;
      dx_r         <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (pix_write) begin
        if ((11'(in_col_r) + 11'd1) >= w_eff) begin
          in_col_r <= '0;
          if ((13'(in_row_r) + 13'd1) >= h_eff) begin
            in_row_r     <= '0;
            in_slot_r    <= '0;
            input_done_r <= 1'b1;
          end else begin
            in_row_r  <= in_row_r + ROW_W'(1);
            in_slot_r <= (in_slot_r == SLOT_W'(ROWS_KEPT - 1)) ? '0
                       : in_slot_r + SLOT_W'(1);
          end
        end else begin
          in_col_r <= in_col_r + COL_W'(1);
        end
      end
      if (state_r == gbr_pkg::ST_CHECK) begin
        dy_r <= -r_s;
        dx_r <= -r_s;
      end else if (state_r == gbr_pkg::ST_RUN) begin
        if (dx_r == r_s) begin
          dx_r <= -r_s;
          dy_r <= dy_r + DW'(1);
        end else begin
          dx_r <= dx_r + DW'(1);
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
        if (emit_col_wrap) begin
          emit_col_r <= '0;
          if (emit_row_wrap) begin
            emit_row_r   <= '0;
            emit_slot_r  <= '0;
            in_row_r     <= '0;
            in_col_r     <= '0;
            in_slot_r    <= '0;
            input_done_r <= 1'b0;
          end else begin
            emit_row_r  <= emit_row_r + ROW_W'(1);
            emit_slot_r <= (emit_slot_r == SLOT_W'(ROWS_KEPT - 1)) ? '0
                         : emit_slot_r + SLOT_W'(1);
          end
        end else begin
          emit_col_r <= emit_col_r + COL_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_blue_out   <= sat8(acc_b);
      out_green_out  <= sat8(acc_g);
      out_red_out    <= sat8(acc_r);
      out_row        <= emit_row_r;
      out_col        <= emit_col_r;
      out_frame_done <= emit_col_wrap && emit_row_wrap;
    end
  end

  `GBR_ASSERT_NEXT(a_accept_check, accept, state_r == gbr_pkg::ST_CHECK)
  `GBR_ASSERT_ALWAYS(a_no_write_busy, !pix_write || state_r == gbr_pkg::ST_IDLE)
  `GBR_ASSERT_NEXT(a_fin_loads, load_out, out_valid && state_r == gbr_pkg::ST_IDLE)
endmodule
`default_nettype wire

/* bench/gaussian_blur_rgb_clipped_checker.sv */
`timescale 1ns / 1ps
module gaussian_blur_rgb_clipped_checker
  import gbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_blue_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_red_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_blue_out,
  input  logic [7:0]  out_green_out,
  input  logic [7:0]  out_red_out,
  input  logic [11:0] out_row,
  input  logic [9:0]  out_col,
  input  logic        out_frame_done,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          frames_predicted
);
  localparam int LINES = 2 * MAX_RADIUS + 2;

  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } blurred_px_t;

  blurred_px_t    blurred_expected[$];
  logic [23:0]    line_pixels[LINES * MAX_WIDTH];
  int unsigned    fill_row, fill_col, emit_row, emit_col;
  bit             frame_filled;
  logic [1:0]     radius_reg;
  logic [15:0]    tap_weight[4];
  logic [10:0]    width_reg;
  logic [12:0]    height_reg;

  function automatic logic [7:0] floor_clip(logic [63:0] acc);
    logic [63:0] v;
    v = acc >> (2 * WEIGHT_BITS);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  task automatic blur_step(input bit is_drain, input logic [23:0] px);
    int unsigned w, h, r, lim_r, lim_c;
    int          tr, tc;
    logic [63:0] sb, sg, sr, wt;
    logic [23:0] tap;
    blurred_px_t res;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    r = radius_reg;
    sb = 0;
    sg = 0;
    sr = 0;
    if (!is_drain && !frame_filled) begin
      line_pixels[(fill_row % LINES) * MAX_WIDTH + fill_col] = px;
      if (fill_col + 1 >= w) begin
        fill_col = 0;
        if (fill_row + 1 >= h) begin
          fill_row = 0;
          frame_filled = 1;
        end else begin
          fill_row = (fill_row + 1) & 12'hfff;
        end
      end else begin
        fill_col = (fill_col + 1) & 10'h3ff;
      end
    end
    lim_r = (emit_row + r > h - 1) ? h - 1 : emit_row + r;
    lim_c = (emit_col + r > w - 1) ? w - 1 : emit_col + r;
    if (!(frame_filled || fill_row > lim_r || (fill_row == lim_r && fill_col > lim_c)))
      return;
    for (int dy = -int'(r); dy <= int'(r); dy++) begin
      tr = int'(emit_row) + dy;
      if (tr < 0 || tr >= int'(h)) continue;
      for (int dx = -int'(r); dx <= int'(r); dx++) begin
        tc = int'(emit_col) + dx;
        if (tc < 0 || tc >= int'(w)) continue;
        tap = line_pixels[(tr % LINES) * MAX_WIDTH + tc];
        wt = 64'(tap_weight[dy < 0 ? -dy : dy]) * 64'(tap_weight[dx < 0 ? -dx : dx]);
        sb += 64'(tap[7:0]) * wt;
        sg += 64'(tap[15:8]) * wt;
        sr += 64'(tap[23:16]) * wt;
      end
    end
    res.blue = floor_clip(sb);
    res.green = floor_clip(sg);
    res.red = floor_clip(sr);
    res.row = emit_row[11:0];
    res.col = emit_col[9:0];
    res.last = 0;
    if (emit_col + 1 >= w) begin
      emit_col = 0;
      if (emit_row + 1 >= h) begin
        res.last = 1;
        emit_row = 0;
        fill_row = 0;
        fill_col = 0;
        frame_filled = 0;
        frames_predicted++;
      end else begin
        emit_row = (emit_row + 1) & 12'hfff;
      end
    end else begin
      emit_col = (emit_col + 1) & 10'h3ff;
    end
    blurred_expected.push_back(res);
  endtask

  task automatic compare_px(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", field, want, got);
      mismatches++;
    end
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
    frames_predicted = 0;
  end

  always @(posedge clk) begin
    blurred_px_t want;
    if (!rst_n) begin
      blurred_expected.delete();
      fill_row = 0;
      fill_col = 0;
      emit_row = 0;
      emit_col = 0;
      frame_filled = 0;
      radius_reg = 2'd3;
      tap_weight[0] = 16'd17740;
      tap_weight[1] = 16'd14205;
      tap_weight[2] = 16'd7293;
      tap_weight[3] = 16'd2400;
      width_reg = 11'd1024;
      height_reg = 13'd1024;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_RADIUS:   radius_reg = cfg_data[1:0];
          REG_W_CENTER: tap_weight[0] = cfg_data;
          REG_W_DIST1:  tap_weight[1] = cfg_data;
          REG_W_DIST2:  tap_weight[2] = cfg_data;
          REG_W_DIST3:  tap_weight[3] = cfg_data;
          REG_WIDTH:    width_reg = cfg_data[10:0];
          REG_HEIGHT:   height_reg = cfg_data[12:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        blur_step(in_req_type, {in_red_in, in_green_in, in_blue_in});
      if (out_valid && out_ready) begin
        if (blurred_expected.size() == 0) begin
          $error("unexpected pixel at row %0d col %0d", out_row, out_col);
          mismatches++;
        end else begin
          want = blurred_expected.pop_front();
          compare_px("blue_out", want.blue, out_blue_out);
          compare_px("green_out", want.green, out_green_out);
          compare_px("red_out", want.red, out_red_out);
          compare_px("out_row", want.row, out_row);
          compare_px("out_col", want.col, out_col);
          compare_px("frame_done", want.last, out_frame_done);
        end
      end
    end
    pending = blurred_expected.size();
  end
endmodule

/* bench/gaussian_blur_rgb_clipped_core_test.sv */
`timescale 1ns / 1ps
module gaussian_blur_rgb_clipped_core_test;
  import gbr_pkg::*;

  logic        clk;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        in_req_type = 0;
  logic [7:0]  in_blue_in = 0;
  logic [7:0]  in_green_in = 0;
  logic [7:0]  in_red_in = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [7:0]  out_blue_out, out_green_out, out_red_out;
  logic [11:0] out_row;
  logic [9:0]  out_col;
  logic        out_frame_done;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = REG_RADIUS;
  logic [15:0] cfg_data = 0;
  int          mismatches, pending, frames_predicted;
  bit          calm = 0;
  int          random_requests = 0;

  gaussian_blur_rgb_clipped_core dut (.*);
  gaussian_blur_rgb_clipped_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (calm || $urandom_range(0, 3) != 0) begin
        out_ready <= 1;
        n = $urandom_range(1, 20);
      end else begin
        out_ready <= 0;
        n = $urandom_range(1, 10);
      end
      repeat (n - 1) @(posedge clk);
    end
  end

  task automatic send_request(input bit is_drain, input logic [7:0] b, g, r);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1;
    in_req_type <= is_drain;
    in_blue_in <= b;
    in_green_in <= g;
    in_red_in <= r;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    random_requests++;
  endtask

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic wait_all_results();
    in_valid <= 0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic run_frame(input logic [1:0] radius, input logic [15:0] w0, w1, w2, w3,
                           input logic [10:0] width, input logic [12:0] height);
    int pixels, frames_seen;
    pixels = ((width == 0) ? 1 : (width > MAX_WIDTH) ? MAX_WIDTH : width) *
             ((height == 0) ? 1 : (height > MAX_HEIGHT) ? MAX_HEIGHT : height);
    wait_all_results();
    write_reg(REG_RADIUS, radius);
    write_reg(REG_W_CENTER, w0);
    write_reg(REG_W_DIST1, w1);
    write_reg(REG_W_DIST2, w2);
    write_reg(REG_W_DIST3, w3);
    write_reg(REG_WIDTH, width);
    write_reg(REG_HEIGHT, height);
    cfg_we <= 0;
    frames_seen = frames_predicted;
    for (int i = 0; i < pixels; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_request(1, 8'($urandom), 8'($urandom), 8'($urandom));
      send_request(0, pick_channel(), pick_channel(), pick_channel());
    end
    while (frames_predicted == frames_seen)
      send_request($urandom_range(0, 3) != 0, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    @(posedge clk);
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    run_frame(2'd3, 16'd17740, 16'd14205, 16'd7293, 16'd2400, 11'd7, 13'd7);
    run_frame(2'd3, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 11'd7, 13'd8);
    run_frame(2'd0, 16'd0, 16'd0, 16'd0, 16'd0, 11'd0, 13'd0);
    run_frame(2'd1, 16'd30000, 16'd17000, 16'd0, 16'd0, 11'd2047, 13'd0);
    random_requests = 0;
    while (random_requests < 250) begin
      if ($urandom_range(0, 2) == 0)
        run_frame(2'($urandom), 16'd17740, 16'd14205, 16'd7293, 16'd2400,
                  11'($urandom_range(7, 12)), 13'($urandom_range(7, 10)));
      else
        run_frame(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  11'($urandom_range(1, 12)), 13'($urandom_range(1, 10)));
    end
    calm = 1;
    run_frame(2'd2, 16'd26000, 16'd15000, 16'd4000, 16'd0, 11'd9, 13'd7);
    in_valid <= 0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

/* files.f */
+incdir+src
src/gbr_pkg.sv
src/gbr_line_mem.sv
src/gbr_tap_mac.sv
src/gaussian_blur_rgb_clipped_core.sv
bench/gaussian_blur_rgb_clipped_checker.sv
bench/gaussian_blur_rgb_clipped_core_test.sv
